// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is high
`define CSETP_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// clocked property that also holds across reset
`define CSETP_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/csetp_pkg.sv -----
// ----------------------------------------------------------------------------
// csetp_pkg
// Shared widths, status codes and control bundles of the exclusive-time
// profiler.
// ----------------------------------------------------------------------------
package csetp_pkg;

   localparam int ID_W       = 8;
   localparam int TS_W       = 32;
   localparam int TOTAL_W    = 32;
   localparam int DEPTH_W    = 7;
   localparam int REQ_DATA_W = 40;   // func_id + timestamp
   localparam int RSP_DATA_W = 48;   // credit_id + credit_total + stack_depth + pad
   localparam int RSP_USER_W = 3;    // status + credit_valid

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_BACKWARD = 2'd3
   } status_type;

   // per-event flags carried down the pipeline
   typedef struct packed {
      status_type status;
      logic       credit;
      logic       from_stack;   // credited id is the interrupted top of stack
      logic       extra;        // end event: count the end tick too
   } ev_ctl_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic rd_en;
   } stack_ctl_type;

   typedef struct packed {
      logic rd_en;
      logic upd_en;
      logic extra;
   } totals_ctl_type;

endpackage

// ----- rtl/core/csetp_stack.sv -----
// ----------------------------------------------------------------------------
// csetp_stack
// Call stack: id memory with a registered top-of-stack read, and the count.
// ----------------------------------------------------------------------------
module csetp_stack #(
   parameter int STACK_DEPTH = 64,
   parameter int CW          = 7
) (
   input  logic                       clock,
   input  logic                       reset,
   input  csetp_pkg::stack_ctl_type   ctl,
   input  logic [csetp_pkg::ID_W-1:0] push_id,
   output logic [CW-1:0]              count,
   output logic                       empty,
   output logic                       full,
   output logic [csetp_pkg::ID_W-1:0] top_id
);
   import csetp_pkg::*;

   localparam int SA = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   logic [ID_W-1:0] stack_mem [STACK_DEPTH];
   logic [ID_W-1:0] top_id_ff;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;
   logic [SA-1:0]   wr_addr;
   logic [SA-1:0]   rd_addr;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff >= CW'(STACK_DEPTH));
   assign wr_addr = SA'(count_ff);
   // top entry; the address is parked at zero when nothing is open
   assign rd_addr = empty ? '0 : SA'(count_ff - CW'(1));

   always_comb begin
      count_in = count_ff;
      if (ctl.push) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         stack_mem[wr_addr] <= push_id;
      end
      if (ctl.rd_en) begin
         top_id_ff <= stack_mem[rd_addr];
      end
   end

   assign count  = count_ff;
   assign top_id = top_id_ff;

endmodule

// ----- rtl/core/csetp_totals.sv -----
// ----------------------------------------------------------------------------
// csetp_totals
// Per-function exclusive-time table: read, saturating add, write back, with
// forwarding of the previous write-back and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module csetp_totals #(
   parameter int FUNC_COUNT = 256,
   parameter int TIME_BITS  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  csetp_pkg::totals_ctl_type     ctl,
   input  logic [$clog2(FUNC_COUNT)-1:0] rd_addr,
   input  logic [$clog2(FUNC_COUNT)-1:0] upd_addr,
   input  logic [TIME_BITS-1:0]          gap,
   output logic                          busy,
   output logic [csetp_pkg::TOTAL_W-1:0] new_total
);
   import csetp_pkg::*;

   localparam int FA = $clog2(FUNC_COUNT);
   localparam int SW = ((TIME_BITS > TOTAL_W) ? TIME_BITS : TOTAL_W) + 1;

   logic [TOTAL_W-1:0] totals_mem [FUNC_COUNT];
   logic [TOTAL_W-1:0] rd_data_ff;
   logic               clr_ff;
   logic [FA-1:0]      clr_idx_ff;
   logic               fwd_v_ff;
   logic [FA-1:0]      fwd_addr_ff;
   logic [TOTAL_W-1:0] fwd_data_ff;
   logic [TOTAL_W-1:0] base;
   logic [SW-1:0]      sum;

   // the write-back issued on the same edge as this read is not in rd_data
   assign base = (fwd_v_ff && (fwd_addr_ff == upd_addr)) ? fwd_data_ff : rd_data_ff;
   assign sum  = SW'(base) + SW'(gap) + SW'(ctl.extra);
   assign new_total = ((sum >> TOTAL_W) != '0) ? TOTAL_MAX : sum[TOTAL_W-1:0];
   assign busy = clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_idx_ff <= '0;
         fwd_v_ff   <= 1'b0;
      end else begin
         if (clr_ff) begin
            clr_idx_ff <= clr_idx_ff + FA'(1);
            if (clr_idx_ff == FA'(FUNC_COUNT - 1)) begin
               clr_ff <= 1'b0;
            end
         end
         if (ctl.upd_en) begin
            fwd_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         totals_mem[clr_idx_ff] <= '0;
      end else if (ctl.upd_en) begin
         totals_mem[upd_addr] <= new_total;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= totals_mem[rd_addr];
      end
      if (ctl.upd_en) begin
         fwd_addr_ff <= upd_addr;
         fwd_data_ff <= new_total;
      end
   end

endmodule

// ----- rtl/core/call_stack_exclusive_time_profiler.sv -----
// ----------------------------------------------------------------------------
// call_stack_exclusive_time_profiler
// Exclusive-time profiler over a stream of function start and end events.
// ----------------------------------------------------------------------------
// Takes one start or end event per clock cycle while rsp is not held off and
// no sweep runs, and returns one result word per event, in order. A result
// passes the s1 and s2 stages and the rsp register, waiting while rsp is held
// off. The stack check, mark compare and push or pop happen on the accepting
// edge; the top-of-stack read and the totals read-modify-write (a registered
// read, the write-back forwarded to the next reader) follow as pipeline stages.
// After reset the totals table is swept to zero, one entry a cycle, so
// req_tready stays low until the sweep is done. Totals saturate at all ones.
module call_stack_exclusive_time_profiler #(
   parameter int FUNC_COUNT  = 256,
   parameter int STACK_DEPTH = 64,
   parameter int TIME_BITS   = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [csetp_pkg::REQ_DATA_W-1:0] req_tdata,   // func_id, timestamp
   input  logic                             req_tuser,   // is_end
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // credit_id, credit_total, stack_depth, zero pad
   output logic [csetp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [csetp_pkg::RSP_USER_W-1:0] rsp_tuser    // status, credit_valid
);
   import csetp_pkg::*;

   localparam int FA = $clog2(FUNC_COUNT);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int TB = TIME_BITS;
   localparam int RS = 2 * ID_W;
   localparam int RM = ((1 << RS) + FUNC_COUNT - 1) / FUNC_COUNT;
   localparam int PW = ID_W + RS + 1;

   // id modulo FUNC_COUNT; quotient by reciprocal multiply, exact for any id
   function automatic logic [ID_W-1:0] id_reduce(input logic [ID_W-1:0] raw);
      logic [PW-1:0]   prod;
      logic [ID_W-1:0] quot;
      logic [PW-1:0]   back;
      prod = PW'(raw) * PW'(RM);
      quot = prod[RS +: ID_W];
      back = PW'(quot) * PW'(FUNC_COUNT);
      if (FUNC_COUNT >= (1 << ID_W)) begin
         return raw;
      end
      return raw - back[ID_W-1:0];
   endfunction

   logic [ID_W-1:0]    req_id;
   logic [TB-1:0]      req_ts;
   logic               accept;
   logic               busy;

   logic [CW-1:0]      count;
   logic               empty;
   logic               full;
   logic [ID_W-1:0]    top_id;
   stack_ctl_type      stack_ctl;

   logic [TB:0]        mark_ff;
   logic [TB:0]        mark_in;
   logic               backward;
   ev_ctl_type         ev_ctl;
   logic [CW-1:0]      depth_after;

   logic               s1_v_ff;
   ev_ctl_type         s1_ctl_ff;
   logic [ID_W-1:0]    s1_id_ff;
   logic [TB-1:0]      s1_gap_ff;
   logic [CW-1:0]      s1_depth_ff;
   logic [ID_W-1:0]    s1_cid;

   logic               s2_v_ff;
   ev_ctl_type         s2_ctl_ff;
   logic [ID_W-1:0]    s2_id_ff;
   logic [TB-1:0]      s2_gap_ff;
   logic [CW-1:0]      s2_depth_ff;

   logic               rsp_v_ff;
   status_type         rsp_status_ff;
   logic               rsp_credit_ff;
   logic [ID_W-1:0]    rsp_id_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;
   logic [DEPTH_W-1:0] rsp_depth_ff;

   logic               out_en;
   logic               en2;
   logic               en1;
   totals_ctl_type     totals_ctl;
   logic [TOTAL_W-1:0] new_total;

   assign req_id = id_reduce(req_tdata[ID_W-1:0]);
   assign req_ts = TB'(req_tdata[ID_W +: TS_W]);

   assign out_en     = !rsp_v_ff || rsp_tready;
   assign en2        = !s2_v_ff || out_en;
   assign en1        = !s1_v_ff || en2;
   assign req_tready = en1 && !busy;
   assign accept     = req_tvalid && req_tready;

   // event decision against the live count and mark
   assign backward = ({1'b0, req_ts} < mark_ff);

   always_comb begin
      ev_ctl.status     = ST_OK;
      ev_ctl.credit     = 1'b0;
      ev_ctl.from_stack = 1'b0;
      ev_ctl.extra      = req_tuser;
      if (req_tuser && empty) begin
         ev_ctl.status = ST_EMPTY;
      end else if (!req_tuser && full) begin
         ev_ctl.status = ST_OVERFLOW;
      end else if (backward) begin
         ev_ctl.status = ST_BACKWARD;
      end else begin
         ev_ctl.credit     = req_tuser || !empty;
         ev_ctl.from_stack = !req_tuser;
      end
   end

   assign stack_ctl.push  = accept && (ev_ctl.status == ST_OK) && !req_tuser;
   assign stack_ctl.pop   = accept && (ev_ctl.status == ST_OK) && req_tuser;
   assign stack_ctl.rd_en = accept;

   always_comb begin
      mark_in     = mark_ff;
      depth_after = count;
      if (stack_ctl.push) begin
         mark_in     = {1'b0, req_ts};
         depth_after = count + CW'(1);
      end else if (stack_ctl.pop) begin
         mark_in     = {1'b0, req_ts} + (TB + 1)'(1);
         depth_after = count - CW'(1);
      end
   end

   csetp_stack #(
      .STACK_DEPTH (STACK_DEPTH),
      .CW          (CW)
   ) u_stack (
      .clock   (clock),
      .reset   (reset),
      .ctl     (stack_ctl),
      .push_id (req_id),
      .count   (count),
      .empty   (empty),
      .full    (full),
      .top_id  (top_id)
   );

   assign s1_cid = s1_ctl_ff.from_stack ? top_id : s1_id_ff;

   assign totals_ctl.rd_en  = en2 && s1_v_ff;
   assign totals_ctl.upd_en = out_en && s2_v_ff && s2_ctl_ff.credit;
   assign totals_ctl.extra  = s2_ctl_ff.extra;

   csetp_totals #(
      .FUNC_COUNT (FUNC_COUNT),
      .TIME_BITS  (TIME_BITS)
   ) u_totals (
      .clock     (clock),
      .reset     (reset),
      .ctl       (totals_ctl),
      .rd_addr   (FA'(s1_cid)),
      .upd_addr  (FA'(s2_id_ff)),
      .gap       (s2_gap_ff),
      .busy      (busy),
      .new_total (new_total)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff  <= '0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         mark_ff <= mark_in;
         if (en1) begin
            s1_v_ff <= accept;
         end
         if (en2) begin
            s2_v_ff <= s1_v_ff;
         end
         if (out_en) begin
            rsp_v_ff <= s2_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctl_ff   <= ev_ctl;
         s1_id_ff    <= req_id;
         s1_gap_ff   <= req_ts - mark_ff[TB-1:0];
         s1_depth_ff <= depth_after;
      end
      if (en2 && s1_v_ff) begin
         s2_ctl_ff   <= s1_ctl_ff;
         s2_id_ff    <= s1_cid;
         s2_gap_ff   <= s1_gap_ff;
         s2_depth_ff <= s1_depth_ff;
      end
      if (out_en && s2_v_ff) begin
         rsp_status_ff <= s2_ctl_ff.status;
         rsp_credit_ff <= s2_ctl_ff.credit;
         rsp_id_ff     <= s2_ctl_ff.credit ? s2_id_ff : '0;
         rsp_total_ff  <= s2_ctl_ff.credit ? new_total : '0;
         rsp_depth_ff  <= DEPTH_W'(s2_depth_ff);
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {1'b0, rsp_depth_ff, rsp_total_ff, rsp_id_ff};
   assign rsp_tuser  = {rsp_credit_ff, rsp_status_ff};

endmodule

// ----- rtl/core/csetp_checker.sv -----
// ----------------------------------------------------------------------------
// csetp_checker
// Port-level checks on the profiler's result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csetp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [csetp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [csetp_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import csetp_pkg::*;

   `CSETP_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_tvalid, "rsp valid after reset")

   `CSETP_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp word changed while stalled")

   `CSETP_ASSERT(a_error_no_credit, clock, reset, rsp_tvalid && (rsp_tuser[1:0] != ST_OK) |-> !rsp_tuser[2], "credit on a dropped event")

   `CSETP_ASSERT(a_no_credit_zero, clock, reset, rsp_tvalid && !rsp_tuser[2] |-> rsp_tdata[39:0] == '0, "id or total set without credit")

endmodule

bind call_stack_exclusive_time_profiler csetp_checker u_csetp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
